/* hw/rtl/ilst_pkg.sv */
// ----------------------------------------------------------------------------
// ilst_pkg
// shared types, codes and widths for the indexed insert/remove list core
// ----------------------------------------------------------------------------
package ilst_pkg;

  localparam int ILST_CAPACITY = 16;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_TUSER_W  = FUNC_W;
  localparam int IN_FIELDS_W = POS_W + VALUE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + STATUS_W + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CAPTURE,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_DONE
  } seq_state_t;

endpackage

/* hw/rtl/ilst_ram.sv */
// ----------------------------------------------------------------------------
// ilst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ilst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/indexed_insert_remove_list_core.sv */
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core
// ordered list of signed 32-bit values with insert, remove, get and set
// ----------------------------------------------------------------------------
// requests arrive on the in_ stream: in_tuser carries the operation, in_tdata
// the position and the value. every request gives one result on the out_
// stream: old or removed value, status, entry count after the operation and
// an empty flag.
// entries live in a single-port-read ram; one read and one write per cycle.
// inserts and removes move the tail of the list one entry at a time (read,
// then write back one slot over), so their cost grows with the entries that
// lie behind the position. each result is registered in the output register
// and shows on out_tvalid from there. in_tready is high only while no request
// is in work; a new request may be taken while the previous result still
// waits in the output register. if the receiver stalls, the next finished
// result waits until the output register frees up.
// reset (rst_n low, synchronous) empties the list; ram contents are not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core #(
  parameter int CAPACITY = ilst_pkg::ILST_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ilst_pkg::IN_TUSER_W-1:0]  in_tuser,   // func
  input  logic [ilst_pkg::IN_TDATA_W-1:0]  in_tdata,   // position, item_value, pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ilst_pkg::OUT_TDATA_W-1:0] out_tdata   // result_value, status,
                                                       // entry_count, is_empty
);
  import ilst_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  seq_state_t          state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [CMP_W-1:0]    pos_r, pos_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [CMP_W-1:0]    idx_r, idx_nxt;
  logic [VALUE_W-1:0]  res_r, res_nxt;
  status_t             st_r, st_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  logic [CMP_W-1:0]    count_ext;
  logic [CMP_W-1:0]    pos_in;
  logic [CMP_W-1:0]    idx_dec;
  logic [CMP_W-1:0]    idx_inc;
  logic [CMP_W-1:0]    cnt_out;
  logic                out_free;

  assign count_ext = CMP_W'(count_r);
  assign pos_in    = CMP_W'(in_tdata[POS_W-1:0]);
  assign idx_dec   = idx_r - CMP_W'(1);
  assign idx_inc   = idx_r + CMP_W'(1);
  assign cnt_out   = CMP_W'(count_nxt);
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ilst_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[ADDR_W-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = pos_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_tuser);
          pos_nxt = pos_in;
          val_nxt = in_tdata[POS_W +: VALUE_W];
          res_nxt = '0;
          st_nxt  = ST_OK;
          if (op_t'(in_tuser) == OP_INSERT) begin
            // range check comes before the full check
            if (pos_in > count_ext) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end else if (count_ext >= CMP_W'(CAPACITY)) begin
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else if (pos_in < count_ext) begin
              idx_nxt   = count_ext;
              state_nxt = S_SH_RD;
            end else begin
              state_nxt = S_INS_WR;
            end
          end else begin
            if (pos_in >= count_ext) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        ram_raddr = pos_r[ADDR_W-1:0];
        state_nxt = S_CAPTURE;
      end
      S_CAPTURE: begin
        res_nxt   = ram_rdata;
        idx_nxt   = pos_r;
        state_nxt = S_DONE;
        if (op_r == OP_SET) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[ADDR_W-1:0];
          ram_wdata = val_r;
        end else if (op_r == OP_REMOVE && (pos_r + CMP_W'(1)) < count_ext) begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        // insert pulls from below, remove pulls from above
        ram_raddr = (op_r == OP_INSERT) ? idx_dec[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (op_r == OP_INSERT) begin
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec > pos_r) ? S_SH_RD : S_INS_WR;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ((idx_r + CMP_W'(2)) < count_ext) ? S_SH_RD : S_DONE;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[ADDR_W-1:0];
        ram_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          if (st_r == ST_OK && op_r == OP_INSERT) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (st_r == ST_OK && op_r == OP_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({(count_nxt == '0), cnt_out[COUNT_W-1:0],
                                        st_r, res_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after a transaction");

  a_count_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == S_DONE)
    else $error("count changed outside result hand-off");

  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_WR |-> idx_r < CMP_W'(CAPACITY))
    else $error("shift index outside list");

endmodule

/* tb/tb_indexed_insert_remove_list_core.sv */
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list_core
// self-checking bench for the indexed insert/remove list core
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. It covers the empty list, the
// value extremes, a fill to capacity, the full and out-of-range errors, and
// removes at both ends. A long random run follows. It drifts between growing,
// shrinking and mixed traffic, so the list keeps passing between empty and
// full, and some positions are out of range. A shadow copy of the list
// predicts each result, but typed table rows use hand-written ones; every
// result is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list_core;
  import ilst_pkg::*;

  localparam int RAND_ITEMS  = 1320;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * ILST_CAPACITY + 8;
  localparam int DIR_N       = 19;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } list_result_t;

  // one row of the directed table; rep repeats the row, rnd_val draws a fresh
  // value per repeat, typed marks rows whose result is written out by hand
  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    logic               rnd_val;
    int                 rep;
    logic               typed;
    logic [VALUE_W-1:0] x_val;
    status_t            x_st;
    logic [COUNT_W-1:0] x_cnt;
    logic               x_empty;
  } dir_row_t;

  typedef enum int {TR_GROW, TR_SHRINK, TR_MIX} trend_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // requests on the empty list
    '{OP_GET,     5'd0,  32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd0,  1'b1},
    '{OP_REMOVE,  5'd0,  32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd0,  1'b1},
    '{OP_SET,     5'd0,  32'd1234,      1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd0,  1'b1},
    '{OP_INSERT,  5'd1,  32'd5,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd0,  1'b1},
    // value extremes
    '{OP_INSERT,  5'd0,  32'h8000_0000, 1'b0, 1,  1'b1, 32'd0,         ST_OK,    5'd1,  1'b0},
    '{OP_INSERT,  5'd0,  32'h7fff_ffff, 1'b0, 1,  1'b1, 32'd0,         ST_OK,    5'd2,  1'b0},
    '{OP_GET,     5'd1,  32'd0,         1'b0, 1,  1'b1, 32'h8000_0000, ST_OK,    5'd2,  1'b0},
    '{OP_SET,     5'd0,  32'hffff_ffff, 1'b0, 1,  1'b1, 32'h7fff_ffff, ST_OK,    5'd2,  1'b0},
    '{OP_GET,     5'd31, 32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd2,  1'b0},
    // fill to capacity in the middle
    '{OP_INSERT,  5'd2,  32'd0,         1'b1, 14, 1'b0, 32'd0,         ST_OK,    5'd0,  1'b0},
    // full list, and the range check ahead of the full check
    '{OP_INSERT,  5'd16, 32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_FULL,  5'd16, 1'b0},
    '{OP_INSERT,  5'd17, 32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd16, 1'b0},
    '{OP_INSERT,  5'd0,  32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_FULL,  5'd16, 1'b0},
    '{OP_GET,     5'd16, 32'd0,         1'b0, 1,  1'b1, 32'd0,         ST_RANGE, 5'd16, 1'b0},
    '{OP_GET,     5'd15, 32'd0,         1'b0, 1,  1'b0, 32'd0,         ST_OK,    5'd0,  1'b0},
    // remove the last entry, then the first one
    '{OP_REMOVE,  5'd15, 32'd0,         1'b0, 1,  1'b0, 32'd0,         ST_OK,    5'd0,  1'b0},
    '{OP_REMOVE,  5'd0,  32'd0,         1'b0, 1,  1'b0, 32'd0,         ST_OK,    5'd0,  1'b0},
    '{OP_SET,     5'd13, 32'd0,         1'b0, 1,  1'b0, 32'd0,         ST_OK,    5'd0,  1'b0},
    '{OP_GET,     5'd0,  32'd0,         1'b0, 1,  1'b1, 32'h8000_0000, ST_OK,    5'd14, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // func
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // position, item_value, pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // result_value, status, entry_count,
                                           // is_empty

  indexed_insert_remove_list_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the list
  logic [VALUE_W-1:0] list_mem [ILST_CAPACITY];
  int                 list_len = 0;

  list_result_t pending_results [$];
  int           errors = 0;
  int           cyc = 0;
  int           n_sent = 0;
  int           n_checked = 0;
  int           n_ok = 0;
  int           n_range = 0;
  int           n_full = 0;
  int           n_at_cap = 0;
  int           n_at_empty = 0;

  function automatic list_result_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                                 logic [VALUE_W-1:0] val);
    list_result_t r;
    int p;
    r.value  = '0;
    r.status = ST_OK;
    p = int'(pos);
    if (op == OP_INSERT) begin
      if (p > list_len) begin
        r.status = ST_RANGE;
      end else if (list_len >= ILST_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
        list_mem[p] = val;
        list_len++;
      end
    end else if (p >= list_len) begin
      r.status = ST_RANGE;
    end else begin
      r.value = list_mem[p];
      if (op == OP_REMOVE) begin
        for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_mem[list_len-1] = '0;
        list_len--;
      end else if (op == OP_SET) begin
        list_mem[p] = val;
      end
    end
    r.count = COUNT_W'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(op_t op, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, val, pos};
    n_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(bit fast);
    int r;
    r = $urandom_range(0, 99);
    if (fast || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, with stretches of full speed
  initial begin
    int  stall_left;
    int  rx_cyc;
    int  r;
    bit  rx_fast;
    stall_left = 0;
    rx_cyc = 0;
    rx_fast = 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc % 300 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_fast) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // result checker
  list_result_t head;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected, tdata %h", out_tdata);
        errors++;
      end else begin
        head = pending_results.pop_front();
        n_checked++;
        if (out_tdata[VALUE_W-1:0] !== head.value) begin
          $error("result_value: expected %h, got %h", head.value, out_tdata[VALUE_W-1:0]);
          errors++;
        end
        if (out_tdata[VALUE_W +: STATUS_W] !== head.status) begin
          $error("status: expected %0d, got %0d", head.status,
                 out_tdata[VALUE_W +: STATUS_W]);
          errors++;
        end
        if (out_tdata[VALUE_W+STATUS_W +: COUNT_W] !== head.count) begin
          $error("entry_count: expected %0d, got %0d", head.count,
                 out_tdata[VALUE_W+STATUS_W +: COUNT_W]);
          errors++;
        end
        if (out_tdata[OUT_FIELDS_W-1] !== head.empty) begin
          $error("is_empty: expected %0d, got %0d", head.empty, out_tdata[OUT_FIELDS_W-1]);
          errors++;
        end
        case (head.status)
          ST_OK:    n_ok++;
          ST_RANGE: n_range++;
          default:  n_full++;
        endcase
        if (head.count == COUNT_W'(ILST_CAPACITY)) n_at_cap++;
        if (head.empty) n_at_empty++;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    list_result_t pred;
    list_result_t typed_res;
    dir_row_t     row;
    op_t          op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    trend_t       trend;
    int           trend_left;
    int           sel;
    bit           tx_fast;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int k = 0; k < DIR_N; k++) begin
      row = DIR_TAB[k];
      for (int j = 0; j < row.rep; j++) begin
        val  = row.rnd_val ? $urandom : row.val;
        pred = apply_list_op(row.op, row.pos, val);
        if (row.typed) begin
          typed_res.value  = row.x_val;
          typed_res.status = row.x_st;
          typed_res.count  = row.x_cnt;
          typed_res.empty  = row.x_empty;
          pending_results.push_back(typed_res);
        end else begin
          pending_results.push_back(pred);
        end
        send_request(row.op, row.pos, val, pick_gap(1'b0));
      end
    end
    wait_all_results();

    // random traffic drifting between growth and shrinkage
    trend = TR_MIX;
    trend_left = 0;
    tx_fast = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (trend_left == 0) begin
        sel = $urandom_range(0, 2);
        trend = (sel == 0) ? TR_GROW : (sel == 1) ? TR_SHRINK : TR_MIX;
        trend_left = $urandom_range(40, 160);
        tx_fast = ($urandom_range(0, 3) == 0);
      end
      trend_left--;

      sel = $urandom_range(0, 99);
      case (trend)
        TR_GROW: begin
          if (sel < 65) op = OP_INSERT;
          else if (sel < 80) op = OP_REMOVE;
          else if (sel < 90) op = OP_GET;
          else op = OP_SET;
        end
        TR_SHRINK: begin
          if (sel < 60) op = OP_REMOVE;
          else if (sel < 75) op = OP_INSERT;
          else if (sel < 88) op = OP_GET;
          else op = OP_SET;
        end
        default: begin
          if (sel < 25) op = OP_INSERT;
          else if (sel < 50) op = OP_REMOVE;
          else if (sel < 75) op = OP_GET;
          else op = OP_SET;
        end
      endcase

      // mostly legal positions, some noise across the whole field
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
      else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, list_len));
      else if (list_len > 0) pos = POS_W'($urandom_range(0, list_len - 1));
      else pos = POS_W'($urandom_range(0, 31));

      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 32'h0000_0000;
          1:       val = 32'h8000_0000;
          2:       val = 32'h7fff_ffff;
          default: val = 32'hffff_ffff;
        endcase
      end else begin
        val = $urandom;
      end

      pending_results.push_back(apply_list_op(op, pos, val));
      send_request(op, pos, val, pick_gap(tx_fast));

      // hold the sender once mid-run until the block has drained
      if (n == RAND_ITEMS / 2) wait_all_results();
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked in %0d cycles", n_sent, n_checked, cyc);
    $display("statuses: %0d ok, %0d out of range, %0d full; at capacity %0d, empty %0d",
             n_ok, n_range, n_full, n_at_cap, n_at_empty);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ilst_pkg.sv
hw/rtl/ilst_ram.sv
hw/rtl/indexed_insert_remove_list_core.sv
tb/tb_indexed_insert_remove_list_core.sv
